### rtl/avsp_pkg.sv
// Shared types, tag codes and decode helpers of the A-XDR value stream parser.
package avsp_pkg;

    localparam int MAX_DEPTH_DEF = 8;
    localparam int STRING_MAX    = 64;
    // Number of string bytes kept and reported for a top-level string.
    localparam logic [15:0] STR_KEEP = 16'(STRING_MAX - 1);

    localparam int TDATA_W = 136;
    localparam int RES_W   = 132;

    // A-XDR type tags.
    localparam logic [7:0] TAG_NULL     = 8'h00;
    localparam logic [7:0] TAG_ARRAY    = 8'h01;
    localparam logic [7:0] TAG_STRUCT   = 8'h02;
    localparam logic [7:0] TAG_BOOL     = 8'h03;
    localparam logic [7:0] TAG_DLONG    = 8'h05;
    localparam logic [7:0] TAG_DLONG_U  = 8'h06;
    localparam logic [7:0] TAG_OCTET    = 8'h09;
    localparam logic [7:0] TAG_VISIBLE  = 8'h0A;
    localparam logic [7:0] TAG_UTF8     = 8'h0C;
    localparam logic [7:0] TAG_INT      = 8'h0F;
    localparam logic [7:0] TAG_LONG     = 8'h10;
    localparam logic [7:0] TAG_UNSIGNED = 8'h11;
    localparam logic [7:0] TAG_LONG_U   = 8'h12;
    localparam logic [7:0] TAG_LONG64   = 8'h14;
    localparam logic [7:0] TAG_LONG64_U = 8'h15;
    localparam logic [7:0] TAG_ENUM     = 8'h16;
    localparam logic [7:0] TAG_FLOAT32  = 8'h17;
    localparam logic [7:0] TAG_FLOAT64  = 8'h18;

    // Long length forms: one or two length bytes follow.
    localparam logic [7:0] LEN_LONG1 = 8'h81;
    localparam logic [7:0] LEN_LONG2 = 8'h82;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_SLEN,
        PH_SEXT,
        PH_ALEN,
        PH_AEXT,
        PH_FIX,
        PH_STR
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_TAG  = 3'd3,
        ST_TOO_DEEP = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  type_tag;
        logic [63:0] value_bits;
        logic [7:0]  str_byte;
        logic        str_byte_valid;
        logic [15:0] string_length;
        logic [31:0] bytes_used;
        logic        value_done;
        status_t     status;
    } result_t;

    // Payload size in bytes of a fixed-size scalar, zero for other tags.
    function automatic logic [3:0] fixed_size(input logic [7:0] tag);
        logic [3:0] n;
        unique case (tag) inside
            TAG_BOOL, TAG_INT, TAG_UNSIGNED, TAG_ENUM:   n = 4'd1;
            TAG_LONG, TAG_LONG_U:                        n = 4'd2;
            TAG_DLONG, TAG_DLONG_U, TAG_FLOAT32:         n = 4'd4;
            TAG_LONG64, TAG_LONG64_U, TAG_FLOAT64:       n = 4'd8;
            default:                                     n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_string_tag(input logic [7:0] tag);
        return (tag == TAG_OCTET) || (tag == TAG_VISIBLE) || (tag == TAG_UTF8);
    endfunction

    // Sign extension for the signed scalars narrower than 64 bits.
    function automatic logic [63:0] extend_value(input logic [7:0] tag,
                                                 input logic [63:0] v);
        logic [63:0] r;
        unique case (tag)
            TAG_INT:   r = {{56{v[7]}}, v[7:0]};
            TAG_LONG:  r = {{48{v[15]}}, v[15:0]};
            TAG_DLONG: r = {{32{v[31]}}, v[31:0]};
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage

### rtl/axdr_value_stream_parser_unit.sv
// Top level of the A-XDR value stream parser: stream ports, item registers, checks.
//
// Each frame on the input stream carries one A-XDR encoded value, one byte
// per item, with s_tlast on the last byte. The parser reads the type tag and
// the length, decodes fixed-size scalars, copies the leading bytes of a
// top-level string and walks nested arrays and structures without output.
// A result item goes out for every copied string byte, for the byte that
// completes the value, for an error and for a frame cut short. Bytes after a
// completed value or an error give no result up to the end of the frame.
// After the input accept the byte waits in the input register and then passes
// through the decode step into the output register, which drives m_tvalid.
// A new byte is taken every cycle while the receiver does not stall; the rate
// is set by the single decode step between the two registers, including the
// pop search over the count stack.
// When the receiver stalls, the output register holds its item and the input
// register takes one more byte before s_tready falls.
// Reset (synchronous, aresetn low) empties both registers and returns the
// parser to expecting a type tag; the count stack needs no clearing.
module axdr_value_stream_parser_unit #(
    parameter int MAX_DEPTH = avsp_pkg::MAX_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte
    input  logic                         s_tlast,   // frame_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // type_tag[7:0], value_bits[71:8], str_byte[79:72], string_length[95:80],
    // bytes_used[127:96], value_done[128], status[131:129], zero fill above
    output logic [avsp_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tuser    // str_byte_valid
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              core_fire;
    logic              res_valid;
    avsp_pkg::result_t res;
    logic              m_valid_reg;
    avsp_pkg::result_t m_res_reg;

    assign core_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    avsp_parser_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (core_fire),
        .data_byte (in_byte_reg),
        .frame_end (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.str_byte_valid;
    assign m_tdata  = {{(avsp_pkg::TDATA_W - avsp_pkg::RES_W){1'b0}},
                       m_res_reg.status,
                       m_res_reg.value_done,
                       m_res_reg.bytes_used,
                       m_res_reg.string_length,
                       m_res_reg.str_byte,
                       m_res_reg.value_bits,
                       m_res_reg.type_tag};

    // A byte waiting in the input register is neither lost nor altered.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !core_fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input item lost while the decode step was stalled");

    // An accepted byte always lands in the input register.
    a_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted input item not registered");

    // A completed value never carries an error code.
    a_done_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.value_done |-> m_res_reg.status == avsp_pkg::ST_OK)
        else $error("completed value reported with an error status");

    // Copied string bytes are only sent on results without an error.
    a_str_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.str_byte_valid |-> m_res_reg.status == avsp_pkg::ST_OK)
        else $error("string byte sent on an error result");

endmodule

### rtl/avsp_count_stack.sv
// Stack of remaining element counts for nested arrays and structures.
module avsp_count_stack #(
    parameter int MAX_DEPTH = avsp_pkg::MAX_DEPTH_DEF,
    localparam int LVL_W = $clog2(MAX_DEPTH + 1),
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             push,
    input  logic             pop,
    input  logic [15:0]      push_count,
    output logic [LVL_W-1:0] level,
    output logic             pop_done
);

    logic [15:0]      count_reg [MAX_DEPTH];
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    // Finishing an element pops every level whose count runs out; the deepest
    // level that still holds more than one element is the one that survives.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((i < int'(level_reg)) && (count_reg[i] != 16'd1)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign pop_done = !hit;
    assign level    = level_reg;

    always_comb begin
        level_next = level_reg;
        if (clear) begin
            level_next = '0;
        end else if (push) begin
            level_next = level_reg + LVL_W'(1);
        end else if (pop) begin
            level_next = hit ? (LVL_W'(hit_idx) + LVL_W'(1)) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !clear) begin
            count_reg[level_reg[IDX_W-1:0]] <= push_count;
        end else if (pop && !clear && hit) begin
            count_reg[hit_idx] <= count_reg[hit_idx] - 16'd1;
        end
    end

endmodule

### rtl/avsp_parser_core.sv
// Byte-wide parser state and the per-item decode step.
module avsp_parser_core #(
    parameter int MAX_DEPTH = avsp_pkg::MAX_DEPTH_DEF,
    localparam int LVL_W = $clog2(MAX_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              frame_end,
    output logic              res_valid,
    output avsp_pkg::result_t res
);

    avsp_pkg::phase_t phase_reg, phase_next;
    logic [63:0] value_reg, value_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] consumed_reg, consumed_next;
    logic        finished_reg, finished_next;

    logic [LVL_W-1:0] level;
    logic             pop_done;
    logic             push, pop, restart;
    logic             len_req, len_is_str, done, sv;
    logic [3:0]       fsize;
    logic [15:0]      str_idx;
    avsp_pkg::status_t err;

    avsp_count_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (fire && restart),
        .push       (fire && push),
        .pop        (fire && pop),
        .push_count (length_next),
        .level      (level),
        .pop_done   (pop_done)
    );

    assign fsize   = avsp_pkg::fixed_size(data_byte);
    assign str_idx = length_reg - pending_reg;

    // Next state of the parser. The end of a frame returns the registers to
    // their reset values only after the result of the byte has been formed.
    always_comb begin
        phase_next    = phase_reg;
        value_next    = value_reg;
        pending_next  = pending_reg;
        length_next   = length_reg;
        tag_next      = tag_reg;
        consumed_next = consumed_reg;
        finished_next = finished_reg;
        push          = 1'b0;
        pop           = 1'b0;
        restart       = 1'b0;
        len_req       = 1'b0;
        done          = 1'b0;
        sv            = 1'b0;
        err           = avsp_pkg::ST_OK;
        len_is_str    = (phase_reg == avsp_pkg::PH_SLEN) || (phase_reg == avsp_pkg::PH_SEXT);

        if (finished_reg) begin
            restart = frame_end;
        end else begin
            if (consumed_reg != 32'hFFFF_FFFF) begin
                consumed_next = consumed_reg + 32'd1;
            end
            unique case (phase_reg)
                avsp_pkg::PH_TAG: begin
                    if (level == '0) begin
                        tag_next   = data_byte;
                        value_next = '0;
                    end
                    if (data_byte == avsp_pkg::TAG_NULL) begin
                        pop = 1'b1;
                    end else if (fsize != 4'd0) begin
                        phase_next   = avsp_pkg::PH_FIX;
                        pending_next = {12'd0, fsize};
                    end else if (avsp_pkg::is_string_tag(data_byte)) begin
                        phase_next = avsp_pkg::PH_SLEN;
                    end else if ((data_byte == avsp_pkg::TAG_ARRAY) ||
                                 (data_byte == avsp_pkg::TAG_STRUCT)) begin
                        phase_next = avsp_pkg::PH_ALEN;
                    end else begin
                        err = avsp_pkg::ST_BAD_TAG;
                    end
                end
                avsp_pkg::PH_SLEN, avsp_pkg::PH_ALEN: begin
                    if (!data_byte[7]) begin
                        length_next = {8'd0, data_byte};
                        len_req     = 1'b1;
                    end else if ((data_byte == avsp_pkg::LEN_LONG1) ||
                                 (data_byte == avsp_pkg::LEN_LONG2)) begin
                        length_next  = '0;
                        pending_next = (data_byte == avsp_pkg::LEN_LONG1) ? 16'd1 : 16'd2;
                        phase_next   = len_is_str ? avsp_pkg::PH_SEXT : avsp_pkg::PH_AEXT;
                    end else begin
                        err = avsp_pkg::ST_BAD_LEN;
                    end
                end
                avsp_pkg::PH_SEXT, avsp_pkg::PH_AEXT: begin
                    length_next  = {length_reg[7:0], data_byte};
                    pending_next = pending_reg - 16'd1;
                    len_req      = (pending_next == 16'd0);
                end
                avsp_pkg::PH_FIX: begin
                    if (level == '0) begin
                        value_next = {value_reg[55:0], data_byte};
                    end
                    pending_next = pending_reg - 16'd1;
                    pop          = (pending_next == 16'd0);
                end
                avsp_pkg::PH_STR: begin
                    sv           = (level == '0) && (str_idx < avsp_pkg::STR_KEEP);
                    pending_next = pending_reg - 16'd1;
                    pop          = (pending_next == 16'd0);
                end
                default: begin
                    err = avsp_pkg::ST_BAD_TAG;
                end
            endcase

            // A complete length opens a string body, a nested level, or ends
            // an empty element straight away.
            if (len_req) begin
                if (length_next == 16'd0) begin
                    pop = 1'b1;
                end else if (len_is_str) begin
                    phase_next   = avsp_pkg::PH_STR;
                    pending_next = length_next;
                end else if (level >= LVL_W'(MAX_DEPTH)) begin
                    err = avsp_pkg::ST_TOO_DEEP;
                end else begin
                    push       = 1'b1;
                    phase_next = avsp_pkg::PH_TAG;
                end
            end

            if (pop) begin
                phase_next = avsp_pkg::PH_TAG;
                done       = pop_done;
            end

            if ((err != avsp_pkg::ST_OK) || done) begin
                finished_next = 1'b1;
            end
            restart = frame_end;
        end
    end

    // Result of the current item.
    always_comb begin
        res            = '0;
        res_valid      = 1'b0;
        res.type_tag   = tag_next;
        res.bytes_used = consumed_next;
        if (finished_reg) begin
            res_valid = 1'b0;
            res       = '0;
        end else if (err != avsp_pkg::ST_OK) begin
            res_valid  = 1'b1;
            res.status = err;
        end else if (done) begin
            res_valid          = 1'b1;
            res.value_bits     = avsp_pkg::extend_value(tag_next, value_next);
            res.str_byte       = sv ? data_byte : 8'd0;
            res.str_byte_valid = sv;
            if (avsp_pkg::is_string_tag(tag_next)) begin
                res.string_length = (length_next < avsp_pkg::STR_KEEP) ?
                                    length_next : avsp_pkg::STR_KEEP;
            end
            res.value_done = 1'b1;
        end else if (frame_end) begin
            res_valid  = 1'b1;
            res.status = avsp_pkg::ST_TRUNC;
        end else if (sv) begin
            res_valid          = 1'b1;
            res.str_byte       = data_byte;
            res.str_byte_valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= avsp_pkg::PH_TAG;
            value_reg    <= '0;
            pending_reg  <= '0;
            length_reg   <= '0;
            tag_reg      <= '0;
            consumed_reg <= '0;
            finished_reg <= 1'b0;
        end else if (fire) begin
            if (restart) begin
                phase_reg    <= avsp_pkg::PH_TAG;
                value_reg    <= '0;
                pending_reg  <= '0;
                length_reg   <= '0;
                tag_reg      <= '0;
                consumed_reg <= '0;
                finished_reg <= 1'b0;
            end else begin
                phase_reg    <= phase_next;
                value_reg    <= value_next;
                pending_reg  <= pending_next;
                length_reg   <= length_next;
                tag_reg      <= tag_next;
                consumed_reg <= consumed_next;
                finished_reg <= finished_next;
            end
        end
    end

endmodule

### sim/axdr_value_stream_parser_unit_tb.sv
// Self-checking testbench of the A-XDR value stream parser with a byte-level predictor.
module axdr_value_stream_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avsp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [7:0] SCALAR_TAGS [12] = '{
        TAG_BOOL, TAG_DLONG, TAG_DLONG_U, TAG_INT, TAG_LONG, TAG_UNSIGNED,
        TAG_LONG_U, TAG_LONG64, TAG_LONG64_U, TAG_ENUM, TAG_FLOAT32, TAG_FLOAT64
    };
    localparam logic [7:0] STRING_TAGS [3] = '{TAG_OCTET, TAG_VISIBLE, TAG_UTF8};

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    axdr_value_stream_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Parser state as the predictor sees it.
    phase_t      ps_phase;
    logic [15:0] nest_counts [MAX_DEPTH_DEF];
    int          ps_level;
    logic [63:0] ps_acc;
    logic [15:0] ps_pending;
    logic [15:0] ps_len;
    logic [7:0]  ps_top;
    logic [31:0] ps_used;
    logic        ps_finished;

    result_t     due_results[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    logic        src_idle = 1'b1;
    logic        sink_idle = 1'b1;
    int          sink_hold_req = 0;
    byte_q_t     frame_buf;

    function automatic void restart_parser();
        ps_phase    = PH_TAG;
        ps_level    = 0;
        ps_acc      = '0;
        ps_pending  = '0;
        ps_len      = '0;
        ps_top      = '0;
        ps_used     = '0;
        ps_finished = 1'b0;
    endfunction

    function automatic int scalar_bytes(logic [7:0] tag);
        case (tag)
            TAG_BOOL, TAG_INT, TAG_UNSIGNED, TAG_ENUM:  return 1;
            TAG_LONG, TAG_LONG_U:                      return 2;
            TAG_DLONG, TAG_DLONG_U, TAG_FLOAT32:       return 4;
            TAG_LONG64, TAG_LONG64_U, TAG_FLOAT64:     return 8;
            default:                                   return 0;
        endcase
    endfunction

    function automatic logic string_tag(logic [7:0] tag);
        return tag == TAG_OCTET || tag == TAG_VISIBLE || tag == TAG_UTF8;
    endfunction

    // Counts one finished element against the open containers; 1 when the
    // top-level value is complete.
    function automatic logic close_element();
        ps_phase = PH_TAG;
        while (ps_level > 0) begin
            nest_counts[ps_level-1] = nest_counts[ps_level-1] - 16'd1;
            if (nest_counts[ps_level-1] != 16'd0)
                return 1'b0;
            ps_level--;
        end
        return 1'b1;
    endfunction

    function automatic status_t length_complete(input logic is_str, output logic done);
        done = 1'b0;
        if (ps_len == 16'd0) begin
            done = close_element();
            return ST_OK;
        end
        if (is_str) begin
            ps_phase   = PH_STR;
            ps_pending = ps_len;
            return ST_OK;
        end
        if (ps_level >= MAX_DEPTH_DEF)
            return ST_TOO_DEEP;
        nest_counts[ps_level] = ps_len;
        ps_level++;
        ps_phase = PH_TAG;
        return ST_OK;
    endfunction

    // Advances the predicted parser by one byte and queues the result it causes.
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        status_t     err;
        logic        done;
        logic        sv;
        logic [7:0]  sb;
        logic        is_str;
        logic [15:0] idx;
        logic [63:0] v;
        result_t     r;
        err  = ST_OK;
        done = 1'b0;
        sv   = 1'b0;
        sb   = 8'h00;
        if (ps_finished) begin
            if (last)
                restart_parser();
            return;
        end
        if (ps_used != 32'hFFFF_FFFF)
            ps_used++;
        case (ps_phase)
            PH_TAG: begin
                if (ps_level == 0) begin
                    ps_top = b;
                    ps_acc = '0;
                end
                if (b == TAG_NULL)
                    done = close_element();
                else if (scalar_bytes(b) != 0) begin
                    ps_phase   = PH_FIX;
                    ps_pending = 16'(scalar_bytes(b));
                end else if (string_tag(b))
                    ps_phase = PH_SLEN;
                else if (b == TAG_ARRAY || b == TAG_STRUCT)
                    ps_phase = PH_ALEN;
                else
                    err = ST_BAD_TAG;
            end
            PH_SLEN, PH_ALEN: begin
                is_str = (ps_phase == PH_SLEN);
                if (b < 8'h80) begin
                    ps_len = {8'h00, b};
                    err = length_complete(is_str, done);
                end else if (b == LEN_LONG1 || b == LEN_LONG2) begin
                    ps_len     = '0;
                    ps_pending = (b == LEN_LONG1) ? 16'd1 : 16'd2;
                    ps_phase   = is_str ? PH_SEXT : PH_AEXT;
                end else
                    err = ST_BAD_LEN;
            end
            PH_SEXT, PH_AEXT: begin
                is_str = (ps_phase == PH_SEXT);
                ps_len = {ps_len[7:0], b};
                ps_pending = ps_pending - 16'd1;
                if (ps_pending == 16'd0)
                    err = length_complete(is_str, done);
            end
            PH_FIX: begin
                if (ps_level == 0)
                    ps_acc = {ps_acc[55:0], b};
                ps_pending = ps_pending - 16'd1;
                if (ps_pending == 16'd0)
                    done = close_element();
            end
            PH_STR: begin
                idx = ps_len - ps_pending;
                if (ps_level == 0 && idx < STR_KEEP) begin
                    sv = 1'b1;
                    sb = b;
                end
                ps_pending = ps_pending - 16'd1;
                if (ps_pending == 16'd0)
                    done = close_element();
            end
            default: err = ST_BAD_TAG;
        endcase

        r = '0;
        r.type_tag   = ps_top;
        r.bytes_used = ps_used;
        r.status     = ST_OK;
        if (err != ST_OK) begin
            r.status = err;
            ps_finished = 1'b1;
            if (last)
                restart_parser();
            due_results.push_back(r);
        end else if (done) begin
            case (ps_top)
                TAG_INT:   v = 64'($signed(ps_acc[7:0]));
                TAG_LONG:  v = 64'($signed(ps_acc[15:0]));
                TAG_DLONG: v = 64'($signed(ps_acc[31:0]));
                default:   v = ps_acc;
            endcase
            r.value_bits     = v;
            r.str_byte       = sb;
            r.str_byte_valid = sv;
            if (string_tag(ps_top))
                r.string_length = (ps_len < STR_KEEP) ? ps_len : STR_KEEP;
            r.value_done = 1'b1;
            ps_finished  = 1'b1;
            if (last)
                restart_parser();
            due_results.push_back(r);
        end else if (last) begin
            r.status = ST_TRUNC;
            restart_parser();
            due_results.push_back(r);
        end else if (sv) begin
            r.str_byte       = sb;
            r.str_byte_valid = 1'b1;
            due_results.push_back(r);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    // Frame builders append to frame_buf.
    function automatic void put_len(input int n);
        int form;
        form = $urandom_range(0, 2);
        if (n < 8'h80 && form == 0)
            frame_buf.push_back(8'(n));
        else if (n < 256 && form != 2) begin
            frame_buf.push_back(LEN_LONG1);
            frame_buf.push_back(8'(n));
        end else begin
            frame_buf.push_back(LEN_LONG2);
            frame_buf.push_back(8'(n >> 8));
            frame_buf.push_back(8'(n));
        end
    endfunction

    function automatic logic [7:0] rand_payload();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_leaf(input logic top);
        logic [7:0] tag;
        int         n;
        case ($urandom_range(0, 5))
            0: frame_buf.push_back(TAG_NULL);
            1, 2: begin
                tag = STRING_TAGS[$urandom_range(0, 2)];
                if (top && $urandom_range(0, 3) == 0)
                    n = $urandom_range(58, 70);
                else
                    n = $urandom_range(0, 8);
                frame_buf.push_back(tag);
                put_len(n);
                repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                tag = SCALAR_TAGS[$urandom_range(0, 11)];
                frame_buf.push_back(tag);
                repeat (scalar_bytes(tag)) frame_buf.push_back(rand_payload());
            end
        endcase
    endfunction

    // A well-formed value, nested up to max_nest containers deep.
    function automatic void build_value(input int max_nest);
        int open[$];
        int n;
        int pick;
        do begin
            pick = $urandom_range(0, 9);
            if (pick <= 1 && open.size() < max_nest) begin
                n = $urandom_range(0, 3);
                frame_buf.push_back(pick == 0 ? TAG_ARRAY : TAG_STRUCT);
                put_len(n);
                if (n > 0) begin
                    open.push_back(n);
                    continue;
                end
            end else
                add_leaf(open.size() == 0);
            while (open.size() > 0) begin
                open[open.size()-1] = open[open.size()-1] - 1;
                if (open[open.size()-1] != 0)
                    break;
                void'(open.pop_back());
            end
        end while (open.size() > 0);
    endfunction

    function automatic void build_chain(input int levels);
        repeat (levels) begin
            frame_buf.push_back($urandom_range(0, 1) ? TAG_ARRAY : TAG_STRUCT);
            put_len(1);
        end
        add_leaf(levels == 0);
    endfunction

    // Receiver: draws a stall before each item; a hold request gives one long stall.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (sink_hold_req > 0) begin
                stall = sink_hold_req;
                sink_hold_req = 0;
            end else
                stall = sink_idle ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.type_tag       = m_tdata[7:0];
            got.value_bits     = m_tdata[71:8];
            got.str_byte       = m_tdata[79:72];
            got.str_byte_valid = m_tuser;
            got.string_length  = m_tdata[95:80];
            got.bytes_used     = m_tdata[127:96];
            got.value_done     = m_tdata[128];
            got.status         = status_t'(m_tdata[131:129]);
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected, tag %h status %0d",
                         $time, got.type_tag, got.status);
            end else begin
                want = due_results.pop_front();
                check_field("type_tag", want.type_tag, got.type_tag);
                check_field("value_bits", want.value_bits, got.value_bits);
                check_field("str_byte", want.str_byte, got.str_byte);
                check_field("str_byte_valid", want.str_byte_valid, got.str_byte_valid);
                check_field("string_length", want.string_length, got.string_length);
                check_field("bytes_used", want.bytes_used, got.bytes_used);
                check_field("value_done", want.value_done, got.value_done);
                check_field("status", want.status, got.status);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_scalars();
        send_frame('{TAG_NULL});
        send_frame('{TAG_INT, 8'h80});
        send_frame('{TAG_LONG, 8'h80, 8'h00});
        send_frame('{TAG_DLONG, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_frame('{TAG_DLONG_U, 8'hFF, 8'hFF, 8'hFF, 8'hFE});
        send_frame('{TAG_LONG64, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
        send_frame('{TAG_LONG64_U, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_frame('{TAG_FLOAT32, 8'h3F, 8'h80, 8'h00, 8'h00});
        send_frame('{TAG_FLOAT64, 8'hC0, 8'h09, 8'h21, 8'hFB, 8'h54, 8'h44, 8'h2D, 8'h18});
        send_frame('{TAG_BOOL, 8'h01});
        send_frame('{TAG_UNSIGNED, 8'hFF});
        send_frame('{TAG_LONG_U, 8'hFF, 8'hFF});
        // Bytes after a completed value are dropped up to the end of the frame.
        send_frame('{TAG_ENUM, 8'h7F, 8'hAA, 8'h55});
        send_frame('{8'hFF});
        send_frame('{8'h04, 8'h00, 8'h00});
        send_frame('{TAG_LONG, 8'h12});
        send_frame('{TAG_DLONG});
    endtask

    task automatic test_strings();
        send_frame('{TAG_VISIBLE, 8'h00});
        send_frame('{TAG_OCTET, 8'h03, 8'h00, 8'hFF, 8'h41});
        send_frame('{TAG_UTF8, LEN_LONG1, 8'h02, 8'hC3, 8'hA9});
        // Longer than the kept part: only the leading bytes are copied.
        frame_buf = '{TAG_OCTET, LEN_LONG2, 8'h00, 8'd70};
        for (int i = 0; i < 70; i++)
            frame_buf.push_back(8'(i * 37));
        send_frame(frame_buf);
        frame_buf = '{TAG_VISIBLE, 8'h7F};
        repeat (127) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_frame(frame_buf);
        send_frame('{TAG_VISIBLE, 8'h05, 8'h31, 8'h32});
        send_frame('{TAG_OCTET, 8'h80});
        send_frame('{TAG_OCTET, 8'h83, 8'h01});
        send_frame('{TAG_UTF8, 8'hFF});
        send_frame('{TAG_OCTET, LEN_LONG2, 8'h00});
    endtask

    task automatic test_containers();
        send_frame('{TAG_ARRAY, 8'h00});
        send_frame('{TAG_STRUCT, 8'h02, TAG_LONG_U, 8'h01, 8'h02,
                     TAG_VISIBLE, 8'h02, 8'h61, 8'h62});
        send_frame('{TAG_ARRAY, LEN_LONG2, 8'h00, 8'h02, TAG_NULL,
                     TAG_ARRAY, LEN_LONG1, 8'h00});
        send_frame('{TAG_STRUCT, 8'h01, TAG_OCTET, LEN_LONG2, 8'h00, 8'h03,
                     8'h01, 8'h02, 8'h03, TAG_NULL});
        // Exactly the deepest allowed nesting, an empty array at that depth, then one level more.
        frame_buf = {};
        repeat (MAX_DEPTH_DEF) frame_buf.push_back(TAG_ARRAY);
        frame_buf = {};
        repeat (MAX_DEPTH_DEF) begin
            frame_buf.push_back(TAG_ARRAY);
            frame_buf.push_back(8'h01);
        end
        frame_buf.push_back(TAG_NULL);
        send_frame(frame_buf);
        frame_buf = {};
        repeat (MAX_DEPTH_DEF) begin
            frame_buf.push_back(TAG_STRUCT);
            frame_buf.push_back(8'h01);
        end
        frame_buf.push_back(TAG_ARRAY);
        frame_buf.push_back(8'h00);
        send_frame(frame_buf);
        frame_buf = {};
        repeat (MAX_DEPTH_DEF + 1) begin
            frame_buf.push_back(TAG_ARRAY);
            frame_buf.push_back(8'h01);
        end
        frame_buf.push_back(TAG_NULL);
        send_frame(frame_buf);
        send_frame('{TAG_ARRAY, 8'h80});
        send_frame('{TAG_STRUCT, 8'h83});
        send_frame('{TAG_ARRAY, 8'h02, TAG_INT, 8'h05});
        send_frame('{TAG_STRUCT, 8'h01, 8'hFF, 8'h00});
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold_req = 300;
        frame_buf = '{TAG_VISIBLE, 8'd50};
        repeat (50) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_frame(frame_buf);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int stop_at;
        int keep;
        int pos;
        // Random frames fill the run up to about a thousand bytes in all.
        stop_at = 1000;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0) begin
                src_idle  = $urandom_range(0, 1);
                sink_idle = $urandom_range(0, 1);
            end
            frame_buf = {};
            case ($urandom_range(0, 19))
                14, 15: build_chain($urandom_range(6, 10));
                16, 17: repeat ($urandom_range(1, 6))
                            frame_buf.push_back(8'($urandom_range(0, 255)));
                default: build_value($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    keep = $urandom_range(1, frame_buf.size());
                    while (frame_buf.size() > keep)
                        void'(frame_buf.pop_back());
                end
                1: begin
                    pos = $urandom_range(0, frame_buf.size() - 1);
                    frame_buf[pos] = 8'($urandom_range(0, 255));
                end
                2: repeat ($urandom_range(1, 3))
                       frame_buf.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
            send_frame(frame_buf);
        end
    endtask

    initial begin
        restart_parser();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_scalars();
        test_strings();
        test_containers();
        test_backpressure();
        test_random_frames();

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### axdr_value_stream_parser_unit.f
rtl/avsp_pkg.sv
rtl/avsp_count_stack.sv
rtl/avsp_parser_core.sv
rtl/axdr_value_stream_parser_unit.sv
sim/axdr_value_stream_parser_unit_tb.sv
